// ===== rtl/adjacency_row_stats_tracker_macros.svh =====
// assertion macros for the adjacency row statistics tracker
// used by the port checker; expects clk and rst_n in scope
`ifndef ADJACENCY_ROW_STATS_TRACKER_MACROS_SVH
`define ADJACENCY_ROW_STATS_TRACKER_MACROS_SVH

// condition in a cycle implies a consequence in the same cycle
`define ARST_ASSERT_NOW(label, cond, conseq) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (conseq)) \
        else $error("%m: same-cycle check failed");

// condition in a cycle implies a consequence in the next cycle
`define ARST_ASSERT_NEXT(label, cond, conseq) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (conseq)) \
        else $error("%m: next-cycle check failed");

`endif

// ===== rtl/arst_pkg.sv =====
// shared types and constants of the adjacency row statistics tracker
// no dependencies
package arst_pkg;

    localparam int MAX_NODES      = 64;
    localparam int WEIGHT_BITS    = 8;
    localparam int NODE_BITS      = $clog2(MAX_NODES);
    localparam int CFG_BITS       = 7;
    localparam int DEGREE_BITS    = 7;
    localparam int TOTAL_BITS     = 14;
    localparam int QUEUE_DEPTH    = 4;
    localparam int QUEUE_PTR_BITS = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_BITS = $clog2(QUEUE_DEPTH + 1);

    localparam logic [CFG_BITS-1:0]    CFG_RESET  = CFG_BITS'(MAX_NODES);
    localparam logic [DEGREE_BITS-1:0] DEGREE_MAX = {DEGREE_BITS{1'b1}};
    localparam logic [TOTAL_BITS-1:0]  TOTAL_MAX  = {TOTAL_BITS{1'b1}};

    typedef logic [WEIGHT_BITS-1:0] weight_t;
    typedef logic [NODE_BITS-1:0]   node_t;
    typedef logic [DEGREE_BITS-1:0] degree_t;
    typedef logic [TOTAL_BITS-1:0]  total_t;
    typedef logic [CFG_BITS-1:0]    cfg_t;

    // one classified matrix element
    typedef struct packed {
        weight_t weight;
        node_t   row;
        node_t   col;
        logic    row_end;
        logic    mat_end;
    } item_t;

    // one matrix result
    typedef struct packed {
        node_t most_links_node;
        node_t largest_sum_node;
        node_t smallest_sum_node;
        logic  smallest_sum_found;
        node_t lightest_link_row;
        node_t lightest_link_col;
        logic  link_found;
    } result_t;

    // queue status seen by front and back
    typedef struct packed {
        logic full;
        logic not_empty;
    } queue_status_t;

endpackage

// ===== rtl/arst_front.sv =====
// front end: takes matrix elements and tags them with position and row/matrix ends
// depends on arst_pkg
module arst_front
    import arst_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cfg_wr_en,
    input  cfg_t          cfg_wr_data,
    input  logic          in_valid,
    input  weight_t       link_weight,
    output logic          in_stall,
    input  queue_status_t queue_status,
    output logic          push,
    output item_t         item
);

    cfg_t  node_count_reg;
    node_t row_pos_reg;
    node_t row_pos_next;
    node_t col_pos_reg;
    node_t col_pos_next;
    node_t last_idx;
    logic  row_end;
    logic  mat_end;

    // last valid index from the node count, with the count clamped to 1..MAX_NODES
    always_comb
    begin
        if (node_count_reg == '0)
        begin
            last_idx = '0;
        end
        else if (node_count_reg > CFG_BITS'(MAX_NODES))
        begin
            last_idx = NODE_BITS'(MAX_NODES - 1);
        end
        else
        begin
            last_idx = NODE_BITS'(node_count_reg - 1'b1);
        end
    end

    // handshake with the queue
    assign in_stall = queue_status.full;
    assign push     = in_valid && !queue_status.full;

    // classification
    assign row_end = (col_pos_reg == last_idx);
    assign mat_end = row_end && (row_pos_reg == last_idx);

    assign item.weight  = link_weight;
    assign item.row     = row_pos_reg;
    assign item.col     = col_pos_reg;
    assign item.row_end = row_end;
    assign item.mat_end = mat_end;

    // position advance
    always_comb
    begin
        row_pos_next = row_pos_reg;
        col_pos_next = col_pos_reg;
        if (push)
        begin
            if (!row_end)
            begin
                col_pos_next = col_pos_reg + 1'b1;
            end
            else
            begin
                col_pos_next = '0;
                row_pos_next = mat_end ? '0 : row_pos_reg + 1'b1;
            end
        end
    end

    // register and position counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            node_count_reg <= CFG_RESET;
            row_pos_reg    <= '0;
            col_pos_reg    <= '0;
        end
        else if (cfg_wr_en)
        begin
            node_count_reg <= cfg_wr_data;
            row_pos_reg    <= '0;
            col_pos_reg    <= '0;
        end
        else
        begin
            row_pos_reg <= row_pos_next;
            col_pos_reg <= col_pos_next;
        end
    end

endmodule

// ===== rtl/arst_queue.sv =====
// short queue of classified elements between front and back
// depends on arst_pkg
module arst_queue
    import arst_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          clear,
    input  logic          push,
    input  item_t         push_item,
    input  logic          pop,
    output item_t         head_item,
    output queue_status_t status
);

    item_t                     entries [QUEUE_DEPTH];
    logic [QUEUE_PTR_BITS-1:0] wr_ptr_reg;
    logic [QUEUE_PTR_BITS-1:0] rd_ptr_reg;
    logic [QUEUE_CNT_BITS-1:0] count_reg;
    logic [QUEUE_CNT_BITS-1:0] count_next;

    assign status.full      = (count_reg == QUEUE_CNT_BITS'(QUEUE_DEPTH));
    assign status.not_empty = (count_reg != '0);
    assign head_item        = entries[rd_ptr_reg];

    // occupancy
    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    // pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else if (clear)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries[wr_ptr_reg] <= push_item;
        end
    end

endmodule

// ===== rtl/arst_back.sv =====
// back end: row accumulation, record updates and the result register
// depends on arst_pkg
module arst_back
    import arst_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    clear,
    input  logic    avail,
    input  item_t   item,
    output logic    pop,
    input  logic    out_stall,
    output logic    out_valid,
    output result_t result
);

    typedef struct packed {
        degree_t row_degree;
        total_t  row_total;
        degree_t best_degree;
        node_t   best_degree_node;
        total_t  best_high_total;
        node_t   best_high_node;
        total_t  best_low_total;
        node_t   best_low_node;
        logic    low_total_valid;
        weight_t min_weight;
        node_t   min_weight_row;
        node_t   min_weight_col;
        logic    min_weight_valid;
    } back_state_t;

    back_state_t st_reg;
    back_state_t st_upd;
    back_state_t st_next;
    logic        out_valid_reg;
    logic        out_valid_next;
    result_t     result_reg;
    result_t     result_next;
    logic        nonzero;
    logic [TOTAL_BITS:0] sum_wide;
    total_t      total_cur;
    degree_t     degree_cur;
    logic        out_free;
    logic        finish;

    // non-final items never wait on the output side
    assign out_free = !out_valid_reg || !out_stall;
    assign pop      = avail && (!item.mat_end || out_free);
    assign finish   = pop && item.mat_end;

    // row accumulation with saturation
    assign nonzero  = (item.weight != '0);
    assign sum_wide = {1'b0, st_reg.row_total} + (TOTAL_BITS + 1)'(item.weight);

    always_comb
    begin
        total_cur  = st_reg.row_total;
        degree_cur = st_reg.row_degree;
        if (nonzero)
        begin
            total_cur = (sum_wide > {1'b0, TOTAL_MAX}) ? TOTAL_MAX
                                                       : sum_wide[TOTAL_BITS-1:0];
            if (st_reg.row_degree != DEGREE_MAX)
            begin
                degree_cur = st_reg.row_degree + 1'b1;
            end
        end
    end

    // record updates for one element
    always_comb
    begin
        st_upd = st_reg;
        if (pop)
        begin
            st_upd.row_total  = total_cur;
            st_upd.row_degree = degree_cur;

            // lightest link, earlier position wins a tie
            if (nonzero && (!st_reg.min_weight_valid || item.weight < st_reg.min_weight))
            begin
                st_upd.min_weight       = item.weight;
                st_upd.min_weight_row   = item.row;
                st_upd.min_weight_col   = item.col;
                st_upd.min_weight_valid = 1'b1;
            end

            // end of row records
            if (item.row_end)
            begin
                if (item.row == '0 || degree_cur > st_reg.best_degree)
                begin
                    st_upd.best_degree      = degree_cur;
                    st_upd.best_degree_node = item.row;
                end
                if (item.row == '0 || total_cur > st_reg.best_high_total)
                begin
                    st_upd.best_high_total = total_cur;
                    st_upd.best_high_node  = item.row;
                end
                if (total_cur != '0
                    && (!st_reg.low_total_valid || total_cur < st_reg.best_low_total))
                begin
                    st_upd.best_low_total  = total_cur;
                    st_upd.best_low_node   = item.row;
                    st_upd.low_total_valid = 1'b1;
                end
                st_upd.row_total  = '0;
                st_upd.row_degree = '0;
            end
        end
    end

    // new state is cleared after a matrix or a register write
    assign st_next = (clear || finish) ? '0 : st_upd;

    // result from the final updated records
    always_comb
    begin
        result_next.most_links_node    = st_upd.best_degree_node;
        result_next.largest_sum_node   = st_upd.best_high_node;
        result_next.smallest_sum_node  = st_upd.low_total_valid ? st_upd.best_low_node : '0;
        result_next.smallest_sum_found = st_upd.low_total_valid;
        result_next.lightest_link_row  = st_upd.min_weight_valid ? st_upd.min_weight_row : '0;
        result_next.lightest_link_col  = st_upd.min_weight_valid ? st_upd.min_weight_col : '0;
        result_next.link_found         = st_upd.min_weight_valid;
    end

    // output valid holds while stalled
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (finish)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            st_reg        <= st_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (finish)
        begin
            result_reg <= result_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign result    = result_reg;

endmodule

// ===== rtl/adjacency_row_stats_tracker.sv =====
// Adjacency row statistics tracker, top level.
// Input channel: in_valid / in_stall with link_weight, one matrix element per
// request in row-major order. Config: cfg_wr_en / cfg_wr_data write node_count
// (0 acts as 1, above 64 as 64) and restart the matrix; write only when idle.
// Output channel: out_valid / out_stall with one result request per matrix,
// issued for the last element.
// Throughput: one element per cycle while in_stall is low; the front tags row
// and matrix ends and the back does one saturating add and the record compares
// per cycle. The last element of a matrix passes through the queue; the back
// pops it after any elements already waiting and registers result and out_valid.
// Reset: node_count returns to 64, positions and records clear, queue empties.
// When out_stall holds the result, elements keep flowing until the final
// element of the next matrix reaches the back; then the four-entry queue
// fills and in_stall rises.
// Depends on arst_pkg, arst_front, arst_queue, arst_back.
module adjacency_row_stats_tracker
    import arst_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    cfg_wr_en,
    input  cfg_t    cfg_wr_data,
    input  logic    in_valid,
    output logic    in_stall,
    input  weight_t link_weight,
    output logic    out_valid,
    input  logic    out_stall,
    output node_t   most_links_node,
    output node_t   largest_sum_node,
    output node_t   smallest_sum_node,
    output logic    smallest_sum_found,
    output node_t   lightest_link_row,
    output node_t   lightest_link_col,
    output logic    link_found
);

    queue_status_t queue_status;
    logic          push;
    logic          pop;
    item_t         front_item;
    item_t         head_item;
    result_t       result;

    // front: accept and classify
    arst_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .in_valid     (in_valid),
        .link_weight  (link_weight),
        .in_stall     (in_stall),
        .queue_status (queue_status),
        .push         (push),
        .item         (front_item)
    );

    // decoupling queue
    arst_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .clear     (cfg_wr_en),
        .push      (push),
        .push_item (front_item),
        .pop       (pop),
        .head_item (head_item),
        .status    (queue_status)
    );

    // back: records and result
    arst_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .clear     (cfg_wr_en),
        .avail     (queue_status.not_empty),
        .item      (head_item),
        .pop       (pop),
        .out_stall (out_stall),
        .out_valid (out_valid),
        .result    (result)
    );

    assign most_links_node    = result.most_links_node;
    assign largest_sum_node   = result.largest_sum_node;
    assign smallest_sum_node  = result.smallest_sum_node;
    assign smallest_sum_found = result.smallest_sum_found;
    assign lightest_link_row  = result.lightest_link_row;
    assign lightest_link_col  = result.lightest_link_col;
    assign link_found         = result.link_found;

endmodule

// ===== rtl/arst_checker.sv =====
// port checker for the adjacency row statistics tracker, bound to the top level
// depends on arst_pkg and adjacency_row_stats_tracker_macros.svh
`include "adjacency_row_stats_tracker_macros.svh"

module arst_checker
    import arst_pkg::*;
(
    input logic    clk,
    input logic    rst_n,
    input logic    out_valid,
    input logic    out_stall,
    input node_t   smallest_sum_node,
    input logic    smallest_sum_found,
    input node_t   lightest_link_row,
    input node_t   lightest_link_col,
    input logic    link_found
);

    logic [2*NODE_BITS-1:0] light_pos;

    // lightest-link position as one word
    assign light_pos = {lightest_link_row, lightest_link_col};

    // a stalled result stays offered with the same lightest link
    `ARST_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(light_pos))

    // no link means the lightest-link position reads zero
    `ARST_ASSERT_NOW(a_no_link_zero, out_valid && !link_found, light_pos == '0)

    // no nonzero row means the smallest-sum node reads zero
    `ARST_ASSERT_NOW(a_no_sum_zero, out_valid && !smallest_sum_found, smallest_sum_node == '0)

    // any nonzero link makes its row sum nonzero
    `ARST_ASSERT_NOW(a_link_gives_sum, out_valid && link_found, smallest_sum_found)

endmodule

bind adjacency_row_stats_tracker arst_checker u_checker (.*);

// ===== tb/adjacency_stats_checker.sv =====
`timescale 1ns / 1ps
// scoreboard for the adjacency row statistics tracker: follows config writes
// and accepted weight requests, predicts each matrix result and compares it
// with the result requests on the output channel; depends on arst_pkg
module adjacency_stats_checker
    import arst_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    cfg_wr_en,
    input  cfg_t    cfg_wr_data,
    input  logic    in_valid,
    input  logic    in_stall,
    input  weight_t link_weight,
    input  logic    out_valid,
    input  logic    out_stall,
    input  node_t   most_links_node,
    input  node_t   largest_sum_node,
    input  node_t   smallest_sum_node,
    input  logic    smallest_sum_found,
    input  node_t   lightest_link_row,
    input  node_t   lightest_link_col,
    input  logic    link_found,
    output int      mismatches,
    output int      awaited
);

    // predicted tracker state
    cfg_t    node_cfg;
    node_t   row_at;
    node_t   col_at;
    degree_t row_links;
    total_t  row_sum;
    degree_t top_links;
    node_t   top_links_node;
    total_t  top_sum;
    node_t   top_sum_node;
    total_t  low_sum;
    node_t   low_sum_node;
    logic    low_sum_seen;
    weight_t light_weight;
    node_t   light_row;
    node_t   light_col;
    logic    light_seen;

    // matrix results still owed by the block, oldest first
    result_t expected_stats[$];
    result_t want;

    function automatic void clear_tracker();
        row_at         = '0;
        col_at         = '0;
        row_links      = '0;
        row_sum        = '0;
        top_links      = '0;
        top_links_node = '0;
        top_sum        = '0;
        top_sum_node   = '0;
        low_sum        = '0;
        low_sum_node   = '0;
        low_sum_seen   = 1'b0;
        light_weight   = '0;
        light_row      = '0;
        light_col      = '0;
        light_seen     = 1'b0;
    endfunction

    function automatic void compare_field(input string field, input logic [7:0] exp_val,
                                          input logic [7:0] act_val);
        if (act_val !== exp_val)
        begin
            $error("%s: expected %0d, got %0d", field, exp_val, act_val);
            mismatches++;
        end
    endfunction

    // fold one matrix element into the row and matrix records
    task automatic take_link(input weight_t w);
        int unsigned           span;
        logic [TOTAL_BITS:0]   wide_sum;
        result_t               fin;
        span = (node_cfg == 0) ? 1 : ((node_cfg > MAX_NODES) ? MAX_NODES : node_cfg);

        if (w != '0)
        begin
            wide_sum = row_sum + w;
            row_sum = (wide_sum > TOTAL_MAX) ? TOTAL_MAX : wide_sum[TOTAL_BITS-1:0];
            if (row_links != DEGREE_MAX)
                row_links++;
            if (!light_seen || w < light_weight)
            begin
                light_weight = w;
                light_row    = row_at;
                light_col    = col_at;
                light_seen   = 1'b1;
            end
        end

        if (col_at + 1 < span)
        begin
            col_at++;
            return;
        end

        // row done: the first row always seeds the high records
        if (row_at == 0 || row_links > top_links)
        begin
            top_links      = row_links;
            top_links_node = row_at;
        end
        if (row_at == 0 || row_sum > top_sum)
        begin
            top_sum      = row_sum;
            top_sum_node = row_at;
        end
        // rows without weight never count as the lightest row
        if (row_sum != 0 && (!low_sum_seen || row_sum < low_sum))
        begin
            low_sum      = row_sum;
            low_sum_node = row_at;
            low_sum_seen = 1'b1;
        end
        row_links = '0;
        row_sum   = '0;
        col_at    = '0;

        if (row_at + 1 < span)
        begin
            row_at++;
            return;
        end

        // matrix done
        fin.most_links_node    = top_links_node;
        fin.largest_sum_node   = top_sum_node;
        fin.smallest_sum_node  = low_sum_seen ? low_sum_node : '0;
        fin.smallest_sum_found = low_sum_seen;
        fin.lightest_link_row  = light_seen ? light_row : '0;
        fin.lightest_link_col  = light_seen ? light_col : '0;
        fin.link_found         = light_seen;
        expected_stats.push_back(fin);
        clear_tracker();
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            node_cfg = CFG_RESET;
            clear_tracker();
            expected_stats.delete();
            mismatches = 0;
            awaited <= 0;
        end
        else
        begin
            // result request against the oldest prediction
            if (out_valid && !out_stall)
            begin
                if (expected_stats.size() == 0)
                begin
                    $error("result request with no matrix result pending");
                    mismatches++;
                end
                else
                begin
                    want = expected_stats.pop_front();
                    compare_field("most_links_node", 8'(want.most_links_node),
                                  8'(most_links_node));
                    compare_field("largest_sum_node", 8'(want.largest_sum_node),
                                  8'(largest_sum_node));
                    compare_field("smallest_sum_node", 8'(want.smallest_sum_node),
                                  8'(smallest_sum_node));
                    compare_field("smallest_sum_found", 8'(want.smallest_sum_found),
                                  8'(smallest_sum_found));
                    compare_field("lightest_link_row", 8'(want.lightest_link_row),
                                  8'(lightest_link_row));
                    compare_field("lightest_link_col", 8'(want.lightest_link_col),
                                  8'(lightest_link_col));
                    compare_field("link_found", 8'(want.link_found), 8'(link_found));
                end
            end

            // a node count write restarts the matrix
            if (cfg_wr_en)
            begin
                node_cfg = cfg_wr_data;
                clear_tracker();
            end

            if (in_valid && !in_stall)
                take_link(link_weight);

            awaited <= expected_stats.size();
        end
    end

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// top of the adjacency row statistics tracker bench: clock, reset, weight
// stimulus, node count writes and output stalls; the verdict comes from
// adjacency_stats_checker; depends on arst_pkg and the tracker RTL
module testbench;
    import arst_pkg::*;

    localparam int LONG_HOLD    = 80;
    localparam int DRAIN_CYCLES = 6;
    localparam int CYCLE_LIMIT  = 600000;
    localparam int SMALL_ITEMS  = 200;

    // how the weights of one matrix are drawn
    typedef enum int
    {
        LINKS_EMPTY,
        LINKS_TIED,
        LINKS_SPARSE,
        LINKS_DENSE
    } link_style_t;

    logic    clk;
    logic    rst_n;
    logic    cfg_wr_en;
    cfg_t    cfg_wr_data;
    logic    in_valid;
    logic    in_stall;
    weight_t link_weight;
    logic    out_valid;
    logic    out_stall;
    node_t   most_links_node;
    node_t   largest_sum_node;
    node_t   smallest_sum_node;
    logic    smallest_sum_found;
    node_t   lightest_link_row;
    node_t   lightest_link_col;
    logic    link_found;

    int      mismatches;
    int      awaited;
    int      max_gap = 6;
    int      hold_requests = 0;
    int      cycle_count = 0;

    adjacency_row_stats_tracker dut
    (
        .clk                (clk),
        .rst_n              (rst_n),
        .cfg_wr_en          (cfg_wr_en),
        .cfg_wr_data        (cfg_wr_data),
        .in_valid           (in_valid),
        .in_stall           (in_stall),
        .link_weight        (link_weight),
        .out_valid          (out_valid),
        .out_stall          (out_stall),
        .most_links_node    (most_links_node),
        .largest_sum_node   (largest_sum_node),
        .smallest_sum_node  (smallest_sum_node),
        .smallest_sum_found (smallest_sum_found),
        .lightest_link_row  (lightest_link_row),
        .lightest_link_col  (lightest_link_col),
        .link_found         (link_found)
    );

    adjacency_stats_checker stats_check
    (
        .clk                (clk),
        .rst_n              (rst_n),
        .cfg_wr_en          (cfg_wr_en),
        .cfg_wr_data        (cfg_wr_data),
        .in_valid           (in_valid),
        .in_stall           (in_stall),
        .link_weight        (link_weight),
        .out_valid          (out_valid),
        .out_stall          (out_stall),
        .most_links_node    (most_links_node),
        .largest_sum_node   (largest_sum_node),
        .smallest_sum_node  (smallest_sum_node),
        .smallest_sum_found (smallest_sum_found),
        .lightest_link_row  (lightest_link_row),
        .lightest_link_col  (lightest_link_col),
        .link_found         (link_found),
        .mismatches         (mismatches),
        .awaited            (awaited)
    );

    // 20 ns clock
    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    function automatic weight_t pick_weight(input link_style_t style);
        case (style)
            LINKS_EMPTY:  return '0;
            LINKS_TIED:   return weight_t'($urandom_range(0, 2));
            LINKS_SPARSE: return ($urandom_range(0, 3) == 0) ?
                                 weight_t'($urandom_range(1, 255)) : '0;
            default:      return weight_t'($urandom_range(0, 255));
        endcase
    endfunction

    // one weight request, after a random gap
    task automatic send_weight(input weight_t w);
        int gap;
        gap = $urandom_range(0, max_gap);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid    <= 1'b1;
        link_weight <= w;
        do
            @(posedge clk);
        while (in_stall);
    endtask

    task automatic send_links(input int count, input link_style_t style);
        repeat (count) send_weight(pick_weight(style));
    endtask

    // stop sending until every result is in and the pipeline has drained
    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (awaited != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_nodes(input cfg_t nodes);
        settle();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= nodes;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
    endtask

    // result side: random stalls per result, plus a long hold when asked
    initial
    begin : receiver
        int gap;
        int holds_done;
        out_stall  = 1'b0;
        holds_done = 0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (holds_done < hold_requests)
            begin
                out_stall <= 1'b1;
                repeat (LONG_HOLD) @(posedge clk);
                holds_done++;
            end
            gap = $urandom_range(0, max_gap);
            if (gap > 0)
            begin
                out_stall <= 1'b1;
                repeat (gap) @(posedge clk);
            end
            out_stall <= 1'b0;
            do
                @(posedge clk);
            while (!out_valid);
        end
    end

    initial
    begin : stimulus
        int          span;
        int          small_sent;
        int          phase;
        int          pick;
        cfg_t        nodes;
        link_style_t style;
        weight_t     two_node_links [14];
        two_node_links = '{0, 0, 0, 0, 1, 2, 2, 1, 0, 0, 7, 0, 9, 9};
        rst_n       = 1'b0;
        cfg_wr_en   = 1'b0;
        cfg_wr_data = '0;
        in_valid    = 1'b0;
        link_weight = '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // node count left at its reset value of 64: a row end but no result yet,
        // the next write throws the partial matrix away
        send_links(MAX_NODES + 16, LINKS_SPARSE);

        // count 0 acts as a single node: no link, largest weight, smallest weight
        write_nodes(cfg_t'(0));
        send_weight(8'd0);
        send_weight(8'd255);
        send_weight(8'd1);

        // two nodes: empty matrix, ties on every record, empty first row,
        // then half a matrix that the next write throws away
        write_nodes(cfg_t'(2));
        foreach (two_node_links[i])
            send_weight(two_node_links[i]);

        // random phases, mostly small matrices
        small_sent = 0;
        phase      = 0;
        while (small_sent < SMALL_ITEMS)
        begin
            pick = $urandom_range(0, 19);
            if (pick == 0)
                nodes = cfg_t'(0);
            else if (pick == 1)
                nodes = cfg_t'(1);
            else if (pick < 16)
                nodes = cfg_t'($urandom_range(2, 4));
            else
                nodes = cfg_t'($urandom_range(5, 8));
            span = (nodes == 0) ? 1 : int'(nodes);
            write_nodes(nodes);
            max_gap = (phase % 4 == 3) ? 0 : 6;

            repeat ($urandom_range(1, 4))
            begin
                pick = $urandom_range(0, 9);
                style = (pick == 0) ? LINKS_EMPTY :
                        (pick < 4)  ? LINKS_TIED  :
                        (pick < 7)  ? LINKS_SPARSE : LINKS_DENSE;
                send_links(span * span, style);
                small_sent += span * span;
                if ($urandom_range(0, 3) == 0)
                    settle();
            end

            // unfinished matrix, dropped by the next write
            if (span > 1 && $urandom_range(0, 4) == 0)
                send_links($urandom_range(1, span * span - 1), LINKS_DENSE);

            phase++;

            // hold results back while single-node matrices keep coming
            if (phase == 1)
            begin
                write_nodes(cfg_t'(1));
                max_gap = 1;
                hold_requests++;
                send_links(40, LINKS_DENSE);
            end
        end

        // largest count, clamped to 64 nodes: past a row end, no result
        max_gap = 6;
        write_nodes(cfg_t'(127));
        send_links(MAX_NODES + 6, LINKS_DENSE);

        settle();
        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
